FILE: design/ple_pkg.sv
// shared types and constants for the positional list engine
// no dependencies
package ple_pkg;

  // list depth and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int DATA_W   = 32;
  localparam int OCNT_W   = 5;

  // command codes
  localparam logic [2:0] CMD_INS_HEAD = 3'd0;
  localparam logic [2:0] CMD_INS_TAIL = 3'd1;
  localparam logic [2:0] CMD_INS_POS  = 3'd2;
  localparam logic [2:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [2:0] CMD_DEL_TAIL = 3'd4;
  localparam logic [2:0] CMD_DEL_POS  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // command word
  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } ple_cmd_t;

  // result word
  typedef struct packed {
    logic [1:0]              status;
    logic signed [DATA_W-1:0] removed_value;
    logic [OCNT_W-1:0]       element_count;
  } ple_res_t;

endpackage

FILE: design/ple_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/positional_list_engine.sv
// positional list engine top level: command decode and shift sequencer
// depends on ple_pkg and ple_ram
//
// Usage: a command word (cmd, value, position) is taken at a clock edge
// where start_i is high and busy is low. Exactly one result word
// (status, removed_value, element_count) follows, shown for one cycle with
// done_o high; the receiver cannot stall it and must take it then.
// Elements live in a CAPACITY-deep ram with one read and one write port;
// every element moved is read and then written back one slot over.
// A rejected or unused command gives its result with no shifting. An
// insert moves the elements from the tail down to the target index up by
// one slot, then writes the value there; a delete captures the removed
// word, then moves the elements above it down by one slot.
// For an insert or delete that is carried out, busy is high from the
// accept until the cycle done_o rises; for a rejected or unused command
// busy stays low. A new command may be given in the same cycle that
// done_o is high. Reset clears the element count and the sequencer; ram
// contents are not cleared, as only entries below the count are ever used.
module positional_list_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ple_pkg::ple_cmd_t cmd_i,
  output logic              busy,
  output logic              done_o,
  output ple_pkg::ple_res_t res_o
);
  import ple_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         count_q;
  logic [IDX_W-1:0]         ptr_q;
  logic [IDX_W-1:0]         tgt_q;
  logic signed [DATA_W-1:0] val_q;
  logic                     done_q;
  ple_res_t                 res_q;

  // decode of the incoming command
  logic [CMP_W-1:0] cnt_x;
  logic [CMP_W-1:0] pos_x;
  logic [1:0]       dec_st;
  logic             dec_ins;
  logic             dec_del;
  logic [IDX_W-1:0] dec_idx;
  logic             accept;

  // ram control
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign accept = start_i && (state_q == S_IDLE);
  assign cnt_x  = CMP_W'(count_q);
  assign pos_x  = CMP_W'(cmd_i.position);

  // check the command against the current fill level
  always_comb begin
    dec_st  = ST_OK;
    dec_ins = 1'b0;
    dec_del = 1'b0;
    dec_idx = '0;
    unique case (cmd_i.cmd)
      CMD_INS_HEAD: begin
        dec_ins = 1'b1;
        if (cnt_x == CMP_W'(CAPACITY)) dec_st = ST_FULL;
      end
      CMD_INS_TAIL: begin
        dec_ins = 1'b1;
        dec_idx = IDX_W'(cnt_x);
        if (cnt_x == CMP_W'(CAPACITY)) dec_st = ST_FULL;
      end
      CMD_INS_POS: begin
        dec_ins = 1'b1;
        dec_idx = IDX_W'(pos_x - CMP_W'(1));
        if (cnt_x == CMP_W'(CAPACITY)) dec_st = ST_FULL;
        else if (pos_x == '0) dec_st = ST_BADPOS;
        else if (pos_x > cnt_x + CMP_W'(1)) dec_st = ST_BADPOS;
      end
      CMD_DEL_HEAD: begin
        dec_del = 1'b1;
        if (cnt_x == '0) dec_st = ST_EMPTY;
      end
      CMD_DEL_TAIL: begin
        dec_del = 1'b1;
        dec_idx = IDX_W'(cnt_x - CMP_W'(1));
        if (cnt_x == '0) dec_st = ST_EMPTY;
      end
      CMD_DEL_POS: begin
        dec_del = 1'b1;
        dec_idx = IDX_W'(pos_x - CMP_W'(1));
        if (cnt_x == '0) dec_st = ST_EMPTY;
        else if (pos_x == '0) dec_st = ST_BADPOS;
        else if (pos_x > cnt_x) dec_st = ST_BADPOS;
      end
      default: begin
      end
    endcase
  end

  // ram address and write steering per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        ram_raddr = dec_idx;
      end
      S_INS_CHK: begin
        ram_raddr = ptr_q - IDX_W'(1);
        if (ptr_q == tgt_q) begin
          ram_we    = 1'b1;
          ram_wdata = val_q;
        end
      end
      S_INS_WR: begin
        ram_we = 1'b1;
      end
      S_DEL_CAP: begin
      end
      S_DEL_CHK: begin
        ram_raddr = ptr_q + IDX_W'(1);
      end
      S_DEL_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer, element count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      ptr_q   <= '0;
      tgt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_q.status        <= dec_st;
            res_q.removed_value <= '0;
            res_q.element_count <= OCNT_W'(cnt_x);
            val_q               <= cmd_i.value;
            if (dec_st != ST_OK || (!dec_ins && !dec_del)) begin
              done_q <= 1'b1;
            end else if (dec_ins) begin
              ptr_q   <= IDX_W'(cnt_x);
              tgt_q   <= dec_idx;
              state_q <= S_INS_CHK;
            end else begin
              ptr_q   <= dec_idx;
              tgt_q   <= IDX_W'(cnt_x - CMP_W'(1));
              state_q <= S_DEL_CAP;
            end
          end
        end
        // shift up until the gap reaches the target slot
        S_INS_CHK: begin
          if (ptr_q == tgt_q) begin
            count_q             <= CNT_W'(cnt_x + CMP_W'(1));
            res_q.element_count <= OCNT_W'(cnt_x + CMP_W'(1));
            done_q              <= 1'b1;
            state_q             <= S_IDLE;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          ptr_q   <= ptr_q - IDX_W'(1);
          state_q <= S_INS_CHK;
        end
        // grab the word being removed
        S_DEL_CAP: begin
          res_q.removed_value <= ram_rdata;
          state_q             <= S_DEL_CHK;
        end
        // shift down until the last slot is reached
        S_DEL_CHK: begin
          if (ptr_q == tgt_q) begin
            count_q             <= CNT_W'(cnt_x - CMP_W'(1));
            res_q.element_count <= OCNT_W'(cnt_x - CMP_W'(1));
            done_q              <= 1'b1;
            state_q             <= S_IDLE;
          end else begin
            state_q <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          ptr_q   <= ptr_q + IDX_W'(1);
          state_q <= S_DEL_CHK;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  ple_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
